// ===== rtl/vafp_pkg.sv =====
// Shared types, widths and constants for the vector angle pipeline.
package vafp_pkg;

  localparam int unsigned TABLE_LEN = 24;
  localparam int unsigned DEF_CORDIC_STAGES = 16;

  localparam int unsigned CW = 16;  // coordinate width
  localparam int unsigned DW = 17;  // difference width
  localparam int unsigned XW = 28;  // CORDIC x/y width
  localparam int unsigned ZW = 33;  // angle accumulator, turns * 2^32
  localparam int unsigned MW = 32;  // angle magnitude width
  localparam int unsigned KW = 31;  // unit conversion constant width
  localparam int unsigned PW = 63;  // product width
  localparam int unsigned AW = 16;  // output angle width

  localparam logic signed [ZW-1:0] Z_QUARTER  = 33'sh0_4000_0000;
  localparam logic signed [ZW-1:0] Z_NQUARTER = 33'sh1_C000_0000;
  localparam logic signed [ZW-1:0] Z_HALF     = 33'sh0_8000_0000;
  localparam logic signed [ZW-1:0] Z_NHALF    = 33'sh1_8000_0000;

  localparam logic [KW-1:0] DEG_FULL_Q6 = 31'd23040;
  localparam logic [KW-1:0] PI_Q29      = 31'd1686629713;

  // atan(2^-i) in turns scaled by 2^32
  localparam logic [31:0] ATAN_TURNS [TABLE_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef enum logic {
    CFG_WRAP_POSITIVE = 1'b0,
    CFG_USE_RADIANS   = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic zero;       // dx and dy both zero
    logic horiz;      // dy zero
    logic horiz_neg;  // dx negative
    logic dy_pos;     // dy positive
  } vafp_ctl_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    vafp_ctl_t            ctl;
  } vafp_vec_t;

endpackage

// ===== rtl/vafp_in_if.sv =====
// Input channel: start and end point coordinates.
interface vafp_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] end_x;
  logic signed [15:0] end_y;
  logic signed [15:0] start_x;
  logic signed [15:0] start_y;

  modport source (output valid, end_x, end_y, start_x, start_y, input ready);
  modport sink (input valid, end_x, end_y, start_x, start_y, output ready);
endinterface

// ===== rtl/vafp_out_if.sv =====
// Output channel: angle and zero-vector flag.
interface vafp_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] angle_out;
  logic               zero_vector;

  modport source (output valid, angle_out, zero_vector, input ready);
  modport sink (input valid, angle_out, zero_vector, output ready);
endinterface

// ===== rtl/vafp_prep.sv =====
// Entry stage: point difference, quadrant pre-rotation and special-case flags.
module vafp_prep import vafp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic signed [CW-1:0] end_x_i,
  input  logic signed [CW-1:0] end_y_i,
  input  logic signed [CW-1:0] start_x_i,
  input  logic signed [CW-1:0] start_y_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output vafp_vec_t            data_o
);

  logic signed [DW-1:0] dx, dy;
  logic signed [XW-1:0] x0, y0;
  vafp_vec_t            data_d, data_q;
  logic                 valid_q;

  always_comb begin
    dx = DW'(end_x_i) - DW'(start_x_i);
    dy = DW'(end_y_i) - DW'(start_y_i);
    x0 = XW'(dx) <<< 8;
    y0 = XW'(dy) <<< 8;
    data_d.ctl.zero      = (dx == '0) && (dy == '0);
    data_d.ctl.horiz     = (dy == '0);
    data_d.ctl.horiz_neg = dx[DW-1];
    data_d.ctl.dy_pos    = !dy[DW-1] && (dy != '0);
    if (!dx[DW-1]) begin
      data_d.x = x0;
      data_d.y = y0;
      data_d.z = '0;
    end else if (!dy[DW-1]) begin
      data_d.x = y0;
      data_d.y = -x0;
      data_d.z = Z_QUARTER;
    end else begin
      data_d.x = -y0;
      data_d.y = x0;
      data_d.z = Z_NQUARTER;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/vafp_cell.sv =====
// One CORDIC vectoring micro-rotation with its pipeline register.
module vafp_cell import vafp_pkg::*; #(
  parameter int unsigned Idx = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  vafp_vec_t data_i,
  output logic      valid_o,
  input  logic      ready_i,
  output vafp_vec_t data_o
);

  localparam logic signed [ZW-1:0] Step = $signed({1'b0, ATAN_TURNS[Idx]});

  logic signed [XW-1:0] xs, ys;
  vafp_vec_t            data_d, data_q;
  logic                 valid_q;

  always_comb begin
    xs     = data_i.x >>> Idx;
    ys     = data_i.y >>> Idx;
    data_d = data_i;
    if (!data_i.y[XW-1]) begin
      data_d.x = data_i.x + ys;
      data_d.y = data_i.y - xs;
      data_d.z = data_i.z + Step;
    end else begin
      data_d.x = data_i.x - ys;
      data_d.y = data_i.y + xs;
      data_d.z = data_i.z - Step;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/vafp_post.sv =====
// Back end: clamp, range wrap, unit conversion multiply, rounding and sign.
module vafp_post import vafp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wrap_i,
  input  logic                 rad_i,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  vafp_vec_t            data_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic signed [AW-1:0] angle_o,
  output logic                 zero_o
);

  // stage A: magnitude in turns
  logic signed [ZW-1:0] zc, zmag;
  logic                 a_neg_d;
  logic                 a_valid_q, a_ready;
  logic [MW-1:0]        a_mag_q;
  logic                 a_neg_q, a_zero_q, a_rad_q;

  // stage B: product
  logic [KW-1:0]        k;
  logic [PW-1:0]        prod;
  logic                 b_valid_q, b_ready;
  logic [PW-1:0]        b_prod_q;
  logic                 b_neg_q, b_zero_q, b_rad_q;

  // stage C: output register
  logic [PW:0]          rsum;
  logic [AW-1:0]        q;
  logic signed [AW-1:0] angle_d;
  logic                 c_valid_q;
  logic signed [AW-1:0] angle_q;
  logic                 zero_q;

  always_comb begin
    if (data_i.ctl.horiz) begin
      zc = data_i.ctl.horiz_neg ? Z_HALF : '0;
    end else if (data_i.ctl.dy_pos) begin
      if (data_i.z < 0) begin
        zc = '0;
      end else if (data_i.z > Z_HALF) begin
        zc = Z_HALF;
      end else begin
        zc = data_i.z;
      end
    end else begin
      if (data_i.z > 0) begin
        zc = '0;
      end else if (data_i.z < Z_NHALF) begin
        zc = Z_NHALF;
      end else begin
        zc = data_i.z;
      end
    end
    // in wrapped mode the low bits of a negative angle are angle + full turn
    a_neg_d = !wrap_i && zc[ZW-1];
    zmag    = a_neg_d ? -zc : zc;
  end

  assign ready_o = !a_valid_q || a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (ready_o) begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      a_mag_q  <= data_i.ctl.zero ? '0 : zmag[MW-1:0];
      a_neg_q  <= a_neg_d && !data_i.ctl.zero;
      a_zero_q <= data_i.ctl.zero;
      a_rad_q  <= rad_i;
    end
  end

  always_comb begin
    k    = a_rad_q ? PI_Q29 : DEG_FULL_Q6;
    prod = PW'(a_mag_q) * PW'(k);
  end

  assign a_ready = !b_valid_q || b_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (a_ready) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_valid_q && a_ready) begin
      b_prod_q <= prod;
      b_neg_q  <= a_neg_q;
      b_zero_q <= a_zero_q;
      b_rad_q  <= a_rad_q;
    end
  end

  always_comb begin
    if (b_rad_q) begin
      rsum = {1'b0, b_prod_q} + (64'd1 << 47);
      q    = rsum[63:48];
    end else begin
      rsum = {1'b0, b_prod_q} + (64'd1 << 31);
      q    = rsum[47:32];
    end
    if (b_zero_q) begin
      angle_d = '0;
    end else if (b_neg_q) begin
      angle_d = -$signed(q);
    end else begin
      angle_d = $signed(q);
    end
  end

  assign b_ready = !c_valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (b_ready) begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_valid_q && b_ready) begin
      angle_q <= angle_d;
      zero_q  <= b_zero_q;
    end
  end

  assign valid_o = c_valid_q;
  assign angle_o = angle_q;
  assign zero_o  = zero_q;

endmodule

// ===== rtl/vector_angle_from_points_core.sv =====
// Top level: direction angle from two points through a CORDIC cell chain.
//
// Usage:
//   in_ch_i carries one start point and one end point (signed Q12.4) per
//   transaction; out_ch_o returns the direction angle and a zero-vector
//   flag per transaction, in order. Both channels transfer when valid and
//   ready are high at a rising clock edge.
//   cfg_we_i/cfg_idx_i/cfg_wdata_i write the range mode (index 0, reset 1 =
//   0..360) and the unit (index 1, reset 0 = degrees Q9.6, 1 = radians
//   Q3.12). Write them only while no transaction is in flight.
//   Path from input to output valid: entry stage, one cell per
//   micro-rotation, then clamp, multiply and round.
//   Throughput: one transaction per cycle unless out_ch_o stalls; every stage
//   holds a register with its own valid bit, so bubbles close up under
//   back-pressure. When the receiver stalls, the chain keeps filling until
//   every stage is occupied and only then drops in_ch_i.ready.
//   Reset empties the pipeline and loads the register defaults.
module vector_angle_from_points_core import vafp_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = DEF_CORDIC_STAGES
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  vafp_in_if.sink    in_ch_i,
  vafp_out_if.source out_ch_o,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic       cfg_wdata_i
);

  localparam int unsigned NumCells =
    (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;

  logic      wrap_q, rad_q;
  logic      c_valid [NumCells+1];
  logic      c_ready [NumCells+1];
  vafp_vec_t c_data  [NumCells+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_q <= 1'b1;
      rad_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_WRAP_POSITIVE: wrap_q <= cfg_wdata_i;
        CFG_USE_RADIANS:   rad_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  vafp_prep u_prep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_ch_i.valid),
    .ready_o   (in_ch_i.ready),
    .end_x_i   (in_ch_i.end_x),
    .end_y_i   (in_ch_i.end_y),
    .start_x_i (in_ch_i.start_x),
    .start_y_i (in_ch_i.start_y),
    .valid_o   (c_valid[0]),
    .ready_i   (c_ready[0]),
    .data_o    (c_data[0])
  );

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    vafp_cell #(
      .Idx (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (c_valid[g]),
      .ready_o (c_ready[g]),
      .data_i  (c_data[g]),
      .valid_o (c_valid[g+1]),
      .ready_i (c_ready[g+1]),
      .data_o  (c_data[g+1])
    );
  end

  vafp_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wrap_i  (wrap_q),
    .rad_i   (rad_q),
    .valid_i (c_valid[NumCells]),
    .ready_o (c_ready[NumCells]),
    .data_i  (c_data[NumCells]),
    .valid_o (out_ch_o.valid),
    .ready_i (out_ch_o.ready),
    .angle_o (out_ch_o.angle_out),
    .zero_o  (out_ch_o.zero_vector)
  );

  // input may only stall once the whole chain is full behind a stalled output
  a_stall_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ch_i.ready |-> (out_ch_o.valid && !out_ch_o.ready))
    else $error("input stalled while pipeline has room");

  a_zero_angle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch_o.valid && out_ch_o.zero_vector) |-> (out_ch_o.angle_out == '0))
    else $error("zero vector with nonzero angle");

  // the last cell drains whenever the back end has room
  a_chain_drains : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_ch_o.valid |-> c_ready[NumCells])
    else $error("back end blocked with empty output");

endmodule

// ===== tb/vector_angle_from_points_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the point-to-point direction angle pipeline.
module vector_angle_from_points_core_tb;
  import vafp_pkg::*;

  localparam int unsigned STAGES = DEF_CORDIC_STAGES;
  localparam int unsigned LATENCY = STAGES + 4;
  localparam int unsigned HOLD_CYCLES = 3 * LATENCY;
  localparam int unsigned RAND_PHASES = 6;
  localparam int unsigned PHASE_ITEMS = 100;
  localparam longint TURN_HALF = 64'sd2147483648;
  localparam longint TURN_QUARTER = 64'sd1073741824;
  localparam longint TURN_FULL = 64'sd4294967296;

  typedef struct packed {
    logic [15:0] angle;
    logic        zero;
  } angle_res_t;

  typedef struct packed {
    bit                 wrap;
    bit                 rad;
    logic signed [15:0] ex;
    logic signed [15:0] ey;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    bit                 typed;   // expected result given in the row
    logic [15:0]        angle;
    logic               zero;
  } dir_row_t;

  // after reset; horizontal and zero spans are typed in, other rows use direction_of
  localparam dir_row_t DIR_ROWS [24] = '{
    '{1, 0, 0, 0, 0, 0, 1, 0, 1},
    '{1, 0, 32767, -32768, 32767, -32768, 1, 0, 1},
    '{1, 0, 32767, 0, -32768, 0, 1, 0, 0},
    '{1, 0, -32768, 0, 32767, 0, 1, 11520, 0},
    '{1, 0, 0, 16, 0, 0, 0, 0, 0},
    '{1, 0, 0, -16, 0, 0, 0, 0, 0},
    '{1, 0, -16, -16, 0, 0, 0, 0, 0},
    '{1, 0, 32767, 32767, -32768, -32768, 0, 0, 0},
    '{1, 0, -32768, 32767, 32767, -32768, 0, 0, 0},
    '{1, 1, -1, 0, 0, 0, 1, 12868, 0},
    '{1, 1, 1, 0, 0, 0, 1, 0, 0},
    '{1, 1, 1, -1, 0, 0, 0, 0, 0},
    '{1, 1, -32768, -1, 32767, 0, 0, 0, 0},
    '{1, 1, 100, 100, 100, 100, 1, 0, 1},
    '{0, 0, 1, -1, 0, 0, 0, 0, 0},
    '{0, 0, -32768, -1, 32767, 0, 0, 0, 0},
    '{0, 0, -1, 0, 0, 0, 1, 11520, 0},
    '{0, 0, 0, 0, 0, 0, 1, 0, 1},
    '{0, 0, 32767, -32768, -32768, 32767, 0, 0, 0},
    '{0, 1, -32768, -32768, 0, 0, 0, 0, 0},
    '{0, 1, -1, 0, 0, 0, 1, 12868, 0},
    '{0, 1, 3, -32768, -3, 32767, 0, 0, 0},
    '{0, 1, -5, -5, 0, 0, 0, 0, 0},
    '{0, 1, 0, 0, 0, 0, 1, 0, 1}
  };

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic cfg_idx;
  logic cfg_wdata;

  vafp_in_if  in_ch ();
  vafp_out_if out_ch ();

  vector_angle_from_points_core #(
    .CORDIC_STAGES(STAGES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch_i    (in_ch),
    .out_ch_o   (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  angle_res_t pending_angles[$];
  bit wrap_mode;
  bit rad_mode;
  bit calm;       // no idling on either side
  bit hold_req;   // ask the receiver for a long hold-off
  int unsigned n_errors;
  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned n_zero;
  int unsigned n_neg;
  int unsigned n_modes;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #(2_000_000);
    $display("Regression FAIL");
    $finish;
  end

  // Angle of the span from start to end, with CORDIC vectoring on turns * 2^32.
  function automatic angle_res_t direction_of(logic signed [15:0] ex, logic signed [15:0] ey,
                                              logic signed [15:0] sx, logic signed [15:0] sy,
                                              bit wrap, bit rad);
    longint dx, dy, x, y, z, t, xs, ys;
    longint unsigned mag, q;
    bit neg;
    angle_res_t r;
    dx = longint'(ex) - longint'(sx);
    dy = longint'(ey) - longint'(sy);
    r.zero = 1'b0;
    if (dx == 0 && dy == 0) begin
      r.angle = '0;
      r.zero = 1'b1;
      return r;
    end
    if (dy == 0) begin
      z = (dx > 0) ? 64'sd0 : TURN_HALF;
    end else begin
      x = dx * 256;
      y = dy * 256;
      z = 0;
      if (x < 0) begin
        t = x;
        if (y >= 0) begin
          x = y;
          y = -t;
          z = TURN_QUARTER;
        end else begin
          x = -y;
          y = t;
          z = -TURN_QUARTER;
        end
      end
      for (int i = 0; i < STAGES && i < TABLE_LEN; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x += ys;
          y -= xs;
          z += longint'(ATAN_TURNS[i]);
        end else begin
          x -= ys;
          y += xs;
          z -= longint'(ATAN_TURNS[i]);
        end
      end
      if (dy > 0) begin
        if (z < 0) z = 0;
        if (z > TURN_HALF) z = TURN_HALF;
      end else begin
        if (z > 0) z = 0;
        if (z < -TURN_HALF) z = -TURN_HALF;
      end
    end
    if (wrap && z < 0) z += TURN_FULL;
    neg = (z < 0);
    mag = neg ? -z : z;
    if (rad) q = (mag * 64'(PI_Q29) + (64'd1 << 47)) >> 48;
    else     q = (mag * 64'(DEG_FULL_Q6) + (64'd1 << 31)) >> 32;
    r.angle = neg ? 16'(-q) : 16'(q);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    n_errors++;
    $display("%0t: MISMATCH %s: got 0x%04h expected 0x%04h (result %0d)",
             $time, what, got, want, n_checked);
  endtask

  // Called at a falling edge; returns at a falling edge.
  task automatic send_points(logic signed [15:0] ex, logic signed [15:0] ey,
                             logic signed [15:0] sx, logic signed [15:0] sy,
                             bit typed, angle_res_t typed_res);
    while (!calm && $urandom_range(0, 99) < 6) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
      @(negedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.end_x   <= ex;
    in_ch.end_y   <= ey;
    in_ch.start_x <= sx;
    in_ch.start_y <= sy;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    pending_angles.push_back(typed ? typed_res : direction_of(ex, ey, sx, sy, wrap_mode, rad_mode));
    n_sent++;
    if (ex == sx && ey == sy) n_zero++;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_angles.size() != 0) @(negedge clk_i);
  endtask

  task automatic set_mode(bit wrap, bit rad);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_WRAP_POSITIVE;
    cfg_wdata <= wrap;
    @(negedge clk_i);
    cfg_idx   <= CFG_USE_RADIANS;
    cfg_wdata <= rad;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    wrap_mode = wrap;
    rad_mode  = rad;
    n_modes++;
  endtask

  task automatic pick_points(output logic signed [15:0] ex, output logic signed [15:0] ey,
                             output logic signed [15:0] sx, output logic signed [15:0] sy);
    int unsigned sel;
    int d;
    logic signed [15:0] corners [5];
    corners = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1, 16'sd1};
    sel = $urandom_range(0, 99);
    sx = 16'($urandom());
    sy = 16'($urandom());
    ex = 16'($urandom());
    ey = 16'($urandom());
    if (sel < 40) begin
      // fully random span
    end else if (sel < 60) begin
      ex = 16'(int'(sx) + int'($urandom_range(0, 128)) - 64);
      ey = 16'(int'(sy) + int'($urandom_range(0, 128)) - 64);
    end else if (sel < 70) begin
      ey = sy;
    end else if (sel < 78) begin
      ex = sx;
    end else if (sel < 84) begin
      ex = sx;
      ey = sy;
    end else if (sel < 92) begin
      d = int'($urandom_range(1, 4000));
      ex = 16'(int'(sx) + (($urandom_range(0, 1) != 0) ? d : -d));
      ey = 16'(int'(sy) + (($urandom_range(0, 1) != 0) ? d : -d));
    end else begin
      ex = corners[$urandom_range(0, 4)];
      ey = corners[$urandom_range(0, 4)];
      sx = corners[$urandom_range(0, 4)];
      sy = corners[$urandom_range(0, 4)];
    end
  endtask

  // Receiver: random back-pressure plus a long hold-off when hold_req is set.
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      out_ch.ready <= calm || ($urandom_range(0, 99) >= 6);
    end
  end

  always @(posedge clk_i) begin
    angle_res_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_angles.size() == 0) begin
        report_mismatch("unexpected transaction, angle_out", out_ch.angle_out, 16'hxxxx);
      end else begin
        want = pending_angles.pop_front();
        if (out_ch.angle_out !== want.angle)
          report_mismatch("angle_out", out_ch.angle_out, want.angle);
        if (out_ch.zero_vector !== want.zero)
          report_mismatch("zero_vector", 16'(out_ch.zero_vector), 16'(want.zero));
        if (out_ch.angle_out[15]) n_neg++;
        n_checked++;
      end
    end
  end

  initial begin
    logic signed [15:0] ex, ey, sx, sy;
    angle_res_t typed_res;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_WRAP_POSITIVE;
    cfg_wdata = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.end_x = '0;
    in_ch.end_y = '0;
    in_ch.start_x = '0;
    in_ch.start_y = '0;
    wrap_mode = 1'b1;
    rad_mode = 1'b0;
    calm = 1'b0;
    hold_req = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table, starting in the reset mode
    foreach (DIR_ROWS[i]) begin
      if (DIR_ROWS[i].wrap != wrap_mode || DIR_ROWS[i].rad != rad_mode)
        set_mode(DIR_ROWS[i].wrap, DIR_ROWS[i].rad);
      typed_res.angle = DIR_ROWS[i].angle;
      typed_res.zero  = DIR_ROWS[i].zero;
      send_points(DIR_ROWS[i].ex, DIR_ROWS[i].ey, DIR_ROWS[i].sx, DIR_ROWS[i].sy,
                  DIR_ROWS[i].typed, typed_res);
    end

    typed_res = '0;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph < 4) set_mode(ph[0], ph[1]);
      else        set_mode(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      calm = (ph == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 1 && n == 40) begin
          // stall the output while the sender keeps pushing: pipeline fills
          calm = 1'b1;
          hold_req = 1'b1;
        end
        if (ph == 1 && n == 80) calm = 1'b0;
        if (ph == 3 && n == 50) drain_results();
        pick_points(ex, ey, sx, sy);
        send_points(ex, ey, sx, sy, 1'b0, typed_res);
      end
    end
    calm = 1'b0;

    drain_results();
    repeat (LATENCY + 8) @(posedge clk_i);
    $display("Sent %0d point pairs (%0d zero spans) across %0d mode settings;",
             n_sent, n_zero, n_modes);
    $display("checked %0d angles (%0d negative), %0d mismatches.",
             n_checked, n_neg, n_errors);
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
